// ===== design/vnke_pkg.sv =====
// ----------------------------------------------------------------------------
// vnke_pkg: shared types and constants for verb/noun key entry
// Holds the entry mode codes, key and glyph characters, and the result record.
// ----------------------------------------------------------------------------
package vnke_pkg;

	typedef enum logic [2:0] {
		MODE_WAIT_VERB  = 3'd0,
		MODE_INPUT_VERB = 3'd1,
		MODE_WAIT_NOUN  = 3'd2,
		MODE_INPUT_NOUN = 3'd3,
		MODE_ENTER      = 3'd4
	} mode_t;

	localparam logic [7:0] KEY_CLEAR = 8'h43;  // 'C'
	localparam logic [7:0] KEY_RESET = 8'h52;  // 'R'
	localparam logic [7:0] KEY_VERB  = 8'h56;  // 'V'
	localparam logic [7:0] KEY_NOUN  = 8'h4E;  // 'N'
	localparam logic [7:0] KEY_ENTER = 8'h45;  // 'E'
	localparam logic [7:0] CHAR_HASH  = 8'h23; // '#'
	localparam logic [7:0] CHAR_UNDER = 8'h5F; // '_'
	localparam logic [7:0] CHAR_SPACE = 8'h20; // ' '
	localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] verb_tens_char;
		logic [7:0] verb_units_char;
		logic [7:0] noun_tens_char;
		logic [7:0] noun_units_char;
		logic       error_lamp;
		logic [7:0] activity_char;
		logic       commit;
		logic [6:0] verb_now;
		logic [6:0] noun_now;
		logic       cleared;
	} result_t;

endpackage

// ===== design/vnke_core.sv =====
// ----------------------------------------------------------------------------
// vnke_core: entry state machine
// Holds the entry state and computes the next state and the result of one key.
// ----------------------------------------------------------------------------
module vnke_core import vnke_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] key,
	output result_t    res
);

	localparam logic [1:0] POS_VT = 2'd0;
	localparam logic [1:0] POS_VU = 2'd1;
	localparam logic [1:0] POS_NT = 2'd2;
	localparam logic [1:0] POS_NU = 2'd3;

	mode_t      mode_q, mode_d;
	logic       pos_q, pos_d;
	logic [6:0] pverb_q, pverb_d;
	logic [6:0] pnoun_q, pnoun_d;
	logic [6:0] sverb_q, sverb_d;
	logic [6:0] snoun_q, snoun_d;
	logic       clean_q, clean_d;
	logic [7:0] disp_q [4];
	logic [7:0] disp_d [4];
	logic       lamp_q, lamp_d;
	logic [7:0] act_q, act_d;
	logic       commit_d;
	logic       clr;
	logic       is_digit;
	logic       run_wait;
	logic [3:0] digit;
	logic [10:0] pverb_x10;
	logic [10:0] pnoun_x10;
	logic [3:0] sv_tens, sv_units, sn_tens, sn_units;

	// Split a 7-bit value into decimal tens (mod 10) and units.
	function automatic logic [7:0] dec2(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [3:0]  t;
		logic [6:0]  u;
		prod = {8'd0, v} * 15'd205;
		q    = prod[14:11];
		t    = (q >= 4'd10) ? q - 4'd10 : q;
		u    = v - {q, 3'b000} - {2'b00, q, 1'b0};
		return {t, u[3:0]};
	endfunction

	assign clr      = (key == KEY_CLEAR) || (key == KEY_RESET);
	assign is_digit = (key >= CHAR_ZERO) && (key <= CHAR_NINE);
	assign digit    = key[3:0];
	assign pverb_x10 = {1'b0, pverb_q, 3'b000} + {3'b000, pverb_q, 1'b0} + {7'd0, digit};
	assign pnoun_x10 = {1'b0, pnoun_q, 3'b000} + {3'b000, pnoun_q, 1'b0} + {7'd0, digit};
	assign {sv_tens, sv_units} = dec2(sverb_d);
	assign {sn_tens, sn_units} = dec2(snoun_d);

	always_comb begin
		mode_t m;
		m        = mode_q;
		mode_d   = mode_q;
		pos_d    = pos_q;
		pverb_d  = pverb_q;
		pnoun_d  = pnoun_q;
		sverb_d  = sverb_q;
		snoun_d  = snoun_q;
		clean_d  = clean_q;
		disp_d   = disp_q;
		lamp_d   = lamp_q;
		act_d    = act_q;
		commit_d = 1'b0;
		run_wait = 1'b0;

		if (clr) begin
			lamp_d = 1'b0;
			act_d  = CHAR_SPACE;
			m      = MODE_WAIT_VERB;
			mode_d = MODE_WAIT_VERB;
		end

		case (m)
			MODE_WAIT_VERB: begin
				run_wait = 1'b1;
			end
			MODE_INPUT_VERB: begin
				if (is_digit) begin
					lamp_d = 1'b0;
					disp_d[pos_q ? POS_VU : POS_VT] = key;
					pverb_d = pverb_x10[6:0];
					mode_d  = pos_q ? MODE_WAIT_NOUN : MODE_INPUT_VERB;
					pos_d   = ~pos_q;
				end else begin
					mode_d = MODE_WAIT_VERB;
				end
			end
			MODE_WAIT_NOUN: begin
				if (key == KEY_NOUN) begin
					disp_d[POS_NT] = CHAR_UNDER;
					disp_d[POS_NU] = CHAR_UNDER;
					mode_d = MODE_INPUT_NOUN;
				end else begin
					mode_d = MODE_WAIT_VERB;
				end
			end
			MODE_INPUT_NOUN: begin
				if (is_digit) begin
					disp_d[pos_q ? POS_NU : POS_NT] = key;
					pnoun_d = pnoun_x10[6:0];
					mode_d  = pos_q ? MODE_ENTER : MODE_INPUT_NOUN;
					pos_d   = ~pos_q;
				end else begin
					mode_d = MODE_WAIT_VERB;
				end
			end
			MODE_ENTER: begin
				mode_d = MODE_WAIT_VERB;
				if (key == KEY_ENTER) begin
					sverb_d  = pverb_q;
					snoun_d  = pnoun_q;
					act_d    = CHAR_HASH;
					clean_d  = 1'b1;
					commit_d = 1'b1;
				end
				run_wait = 1'b1;
			end
			default: begin
				mode_d = MODE_WAIT_VERB;
			end
		endcase

		// Idle handling: an unfinished entry lights the lamp, then the
		// committed pair is shown, and V opens a fresh verb entry.
		if (run_wait) begin
			if (!clean_d) begin
				lamp_d = 1'b1;
			end
			pverb_d = '0;
			pnoun_d = '0;
			pos_d   = 1'b0;
			clean_d = 1'b1;
			disp_d[POS_VT] = CHAR_ZERO + {4'd0, sv_tens};
			disp_d[POS_VU] = CHAR_ZERO + {4'd0, sv_units};
			disp_d[POS_NT] = CHAR_ZERO + {4'd0, sn_tens};
			disp_d[POS_NU] = CHAR_ZERO + {4'd0, sn_units};
			if (key == KEY_VERB) begin
				disp_d[POS_VT] = CHAR_UNDER;
				disp_d[POS_VU] = CHAR_UNDER;
				disp_d[POS_NT] = CHAR_HASH;
				disp_d[POS_NU] = CHAR_HASH;
				mode_d  = MODE_INPUT_VERB;
				clean_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT_VERB;
			pos_q   <= 1'b0;
			pverb_q <= '0;
			pnoun_q <= '0;
			sverb_q <= '0;
			snoun_q <= '0;
			clean_q <= 1'b1;
			disp_q  <= '{default: CHAR_SPACE};
			lamp_q  <= 1'b0;
			act_q   <= CHAR_SPACE;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			pverb_q <= pverb_d;
			pnoun_q <= pnoun_d;
			sverb_q <= sverb_d;
			snoun_q <= snoun_d;
			clean_q <= clean_d;
			disp_q  <= disp_d;
			lamp_q  <= lamp_d;
			act_q   <= act_d;
		end
	end

	always_comb begin
		res.mode            = mode_d;
		res.verb_tens_char  = disp_d[POS_VT];
		res.verb_units_char = disp_d[POS_VU];
		res.noun_tens_char  = disp_d[POS_NT];
		res.noun_units_char = disp_d[POS_NU];
		res.error_lamp      = lamp_d;
		res.activity_char   = act_d;
		res.commit          = commit_d;
		res.verb_now        = sverb_d;
		res.noun_now        = snoun_d;
		res.cleared         = clr;
	end

endmodule

// ===== design/verb_noun_key_entry.sv =====
// ----------------------------------------------------------------------------
// verb_noun_key_entry: verb/noun keyboard entry controller
// Accepts one key code per item and returns one display/status result per key.
// ----------------------------------------------------------------------------
// The key lands in the input register at the accepting edge and its result
//   in the result register when the core advances; a result that is not taken
//   stalls that move. Throughput: one key per cycle while each result is taken.
// The rate is set by the single entry state update between the two registers.
// Reset (arst_n low, asynchronous): both registers empty, wait-verb mode,
//   committed pair 00, lamp off, display and activity characters blank.
// ----------------------------------------------------------------------------
module verb_noun_key_entry import vnke_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_valid,
	output logic       key_ready,
	input  logic [7:0] key_code,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [2:0] mode,
	output logic [7:0] verb_tens_char,
	output logic [7:0] verb_units_char,
	output logic [7:0] noun_tens_char,
	output logic [7:0] noun_units_char,
	output logic       error_lamp,
	output logic [7:0] activity_char,
	output logic       commit,
	output logic [6:0] verb_now,
	output logic [6:0] noun_now,
	output logic       cleared
);

	// Input stage: the accepted key waits here until the result register
	// has room; the state machine advances exactly when it moves on.
	logic       key_valid_s1;
	logic [7:0] key_s1;
	// Result stage: holds a finished result until the consumer takes it.
	logic       res_valid_s2;
	result_t    res_s2;
	result_t    res_next;
	logic       res_room;
	logic       advance;

	// The result register can load when it is empty or being emptied now.
	assign res_room  = !res_valid_s2 || result_ready;
	assign advance   = key_valid_s1 && res_room;
	// A new key is taken when the input register is empty or moving on.
	assign key_ready = !key_valid_s1 || res_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_s1 <= 1'b0;
		end else if (key_ready) begin
			key_valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_ready && key_valid) begin
			key_s1 <= key_code;
		end
	end

	vnke_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.key    (key_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (res_room) begin
			res_valid_s2 <= key_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid    = res_valid_s2;
	assign mode            = res_s2.mode;
	assign verb_tens_char  = res_s2.verb_tens_char;
	assign verb_units_char = res_s2.verb_units_char;
	assign noun_tens_char  = res_s2.noun_tens_char;
	assign noun_units_char = res_s2.noun_units_char;
	assign error_lamp      = res_s2.error_lamp;
	assign activity_char   = res_s2.activity_char;
	assign commit          = res_s2.commit;
	assign verb_now        = res_s2.verb_now;
	assign noun_now        = res_s2.noun_now;
	assign cleared         = res_s2.cleared;

endmodule
